@@ hdl/hc11p_pkg.sv @@
`default_nettype none

package hc11p_pkg;

  // byte kinds out of the opcode lookup
  localparam logic [1:0] KIND_BAD    = 2'd0;
  localparam logic [1:0] KIND_PREFIX = 2'd1;
  localparam logic [1:0] KIND_OP     = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_BASE = 2'd1;
  localparam logic [1:0] ST_BAD_PFX = 2'd2;

  // prefix pages
  localparam logic [1:0] PAGE_NONE = 2'd0;
  localparam logic [1:0] PAGE_18   = 2'd1;
  localparam logic [1:0] PAGE_1A   = 2'd2;
  localparam logic [1:0] PAGE_CD   = 2'd3;

  localparam logic [7:0] PFX_18 = 8'h18;
  localparam logic [7:0] PFX_1A = 8'h1A;

  localparam logic [6:0] CLS_BAD    = 7'd0;
  localparam logic [6:0] CLS_PREFIX = 7'd90;

  // relative forms
  localparam logic [4:0] FORM_REL      = 5'd4;
  localparam logic [4:0] FORM_BRSET_LO = 5'd14;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] pfx_page;
    logic [4:0] form;
    logic [1:0] nops;
  } dec_t;

  // class code: tens digit = length without prefix, units = format
  localparam logic [6:0] BASE_CLASS [256] = '{
    7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,
    7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,
    7'd10,7'd10,7'd41,7'd41,7'd34,7'd34,7'd10,7'd10,
    7'd90,7'd10,7'd90,7'd10,7'd35,7'd35,7'd42,7'd42,
    7'd22,7'd22,7'd22,7'd22,7'd22,7'd22,7'd22,7'd22,
    7'd22,7'd22,7'd22,7'd22,7'd22,7'd22,7'd22,7'd22,
    7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,
    7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,
    7'd11,7'd0 ,7'd0 ,7'd11,7'd11,7'd0 ,7'd11,7'd11,
    7'd11,7'd11,7'd11,7'd0 ,7'd11,7'd11,7'd0 ,7'd11,
    7'd12,7'd0 ,7'd0 ,7'd12,7'd12,7'd0 ,7'd12,7'd12,
    7'd12,7'd12,7'd12,7'd0 ,7'd12,7'd12,7'd0 ,7'd12,
    7'd24,7'd0 ,7'd0 ,7'd24,7'd24,7'd0 ,7'd24,7'd24,
    7'd24,7'd24,7'd24,7'd0 ,7'd24,7'd24,7'd24,7'd24,
    7'd31,7'd0 ,7'd0 ,7'd31,7'd31,7'd0 ,7'd31,7'd31,
    7'd31,7'd31,7'd31,7'd0 ,7'd31,7'd31,7'd31,7'd31,
    7'd23,7'd23,7'd23,7'd32,7'd23,7'd23,7'd23,7'd0 ,
    7'd23,7'd23,7'd23,7'd23,7'd32,7'd22,7'd32,7'd10,
    7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,
    7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,
    7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,
    7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,
    7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,
    7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,
    7'd23,7'd23,7'd23,7'd32,7'd23,7'd23,7'd23,7'd0 ,
    7'd23,7'd23,7'd23,7'd23,7'd32,7'd90,7'd32,7'd10,
    7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,
    7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,7'd21,
    7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,
    7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,7'd24,
    7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,
    7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,7'd31,7'd31
  };

  function automatic logic [6:0] page_class(input logic [1:0] page, input logic [7:0] b);
    logic [6:0] cls;
    cls = CLS_BAD;
    if (page == PAGE_18) begin
      case (b) inside
        8'h08, 8'h09, 8'h30, 8'h35, 8'h38, 8'h3A, 8'h3C, 8'h8F: cls = 7'd10;
        8'h1C, 8'h1D: cls = 7'd36;
        8'h1E, 8'h1F: cls = 7'd43;
        8'h8C, 8'hCE: cls = 7'd32;
        8'h9C, 8'hDE, 8'hDF: cls = 7'd21;
        8'hBC, 8'hFE, 8'hFF: cls = 7'd31;
        8'h60, 8'h63, 8'h64, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
        8'h6C, 8'h6D, 8'h6E, 8'h6F: cls = 7'd25;
        [8'hA0:8'hAF], [8'hE0:8'hEF]: cls = 7'd25;
        default: cls = CLS_BAD;
      endcase
    end else if (page == PAGE_1A) begin
      case (b) inside
        8'h83: cls = 7'd32;
        8'h93: cls = 7'd21;
        8'hA3, 8'hAC, 8'hEE, 8'hEF: cls = 7'd24;
        8'hB3: cls = 7'd31;
        default: cls = CLS_BAD;
      endcase
    end else begin
      case (b) inside
        8'hA3, 8'hAC, 8'hEE, 8'hEF: cls = 7'd25;
        default: cls = CLS_BAD;
      endcase
    end
    return cls;
  endfunction

  // class code to form number 0..16
  function automatic logic [4:0] class_form(input logic [6:0] cls);
    logic [4:0] f;
    case (cls) inside
      [7'd10:7'd12]: f = 5'(cls - 7'd10);
      [7'd21:7'd25]: f = 5'(cls - 7'd18);
      [7'd31:7'd36]: f = 5'(cls - 7'd23);
      [7'd41:7'd43]: f = 5'(cls - 7'd27);
      default:       f = 5'd0;
    endcase
    return f;
  endfunction

  function automatic logic [1:0] form_nops(input logic [4:0] f);
    logic [1:0] n;
    if (f < 5'd3)       n = 2'd0;
    else if (f < 5'd8)  n = 2'd1;
    else if (f < 5'd14) n = 2'd2;
    else                n = 2'd3;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/hc11p_decode.sv @@
`default_nettype none

// Opcode lookup: base table when no prefix is held, else the prefix page table.
module hc11p_decode (
  input  wire logic [1:0]       page,
  input  wire logic [7:0]       code_byte,
  output hc11p_pkg::dec_t       dec
);

  logic [6:0] cls;

  always_comb begin
    if (page == hc11p_pkg::PAGE_NONE) cls = hc11p_pkg::BASE_CLASS[code_byte];
    else                              cls = hc11p_pkg::page_class(page, code_byte);
  end

  always_comb begin
    dec.form     = hc11p_pkg::class_form(cls);
    dec.nops     = hc11p_pkg::form_nops(dec.form);
    dec.pfx_page = hc11p_pkg::PAGE_CD;
    if (code_byte == hc11p_pkg::PFX_18)      dec.pfx_page = hc11p_pkg::PAGE_18;
    else if (code_byte == hc11p_pkg::PFX_1A) dec.pfx_page = hc11p_pkg::PAGE_1A;
    if (cls == hc11p_pkg::CLS_BAD)         dec.kind = hc11p_pkg::KIND_BAD;
    else if (cls == hc11p_pkg::CLS_PREFIX) dec.kind = hc11p_pkg::KIND_PREFIX;
    else                                   dec.kind = hc11p_pkg::KIND_OP;
  end

endmodule

`default_nettype wire

@@ hdl/hc11_instruction_predecoder_core.sv @@
`default_nettype none

// 68HC11 instruction predecoder. Code bytes stream in one per transaction on
// the in_ channel; one result transaction leaves on the out_ channel for each
// complete instruction (or bad opcode), carrying its address, prefix page,
// opcode, addressing form, length, operand bytes and, for relative forms,
// the branch target. The block takes one byte per cycle unless out_ready
// backpressure holds a result: a byte is held in the input register, the
// table lookup plus two 16-bit adds run between that register and the
// result register, and an instruction's result reaches the out_ ports from
// the result register, as long as that register is free. Throughput is
// limited only by out_ready backpressure. A write on the cfg_ channel loads
// the start address and restarts the stream at an instruction boundary; it
// is meant to be issued while no bytes are in flight. cfg_ready is always high.
module hc11_instruction_predecoder_core (
  input  wire  logic        clk,
  input  wire  logic        rst_n,

  input  wire  logic        cfg_valid,
  output logic              cfg_ready,
  input  wire  logic [15:0] cfg_start_address,

  input  wire  logic        in_valid,
  output logic              in_ready,
  input  wire  logic [7:0]  in_code_byte,

  output logic              out_valid,
  input  wire  logic        out_ready,
  output logic [15:0]       out_inst_address,
  output logic [1:0]        out_status,
  output logic [1:0]        out_page,
  output logic [7:0]        out_opcode,
  output logic [4:0]        out_form,
  output logic [2:0]        out_length,
  output logic [7:0]        out_operand_a,
  output logic [7:0]        out_operand_b,
  output logic [7:0]        out_operand_c,
  output logic [15:0]       out_branch_target
);

  // decode phase
  localparam logic [1:0] PH_FIRST = 2'd0;  // expecting first byte
  localparam logic [1:0] PH_PFX   = 2'd1;  // expecting opcode after a prefix
  localparam logic [1:0] PH_OPND  = 2'd2;  // collecting operand bytes

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_go;

  // stream state
  logic [15:0] addr_r, addr_nxt;
  logic [1:0]  page_r, page_nxt;
  logic [7:0]  opc_r, opc_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  op1_r, op1_nxt;
  logic [7:0]  op2_r, op2_nxt;
  logic [4:0]  form_r, form_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] res_addr_r;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [1:0]  res_page_r, res_page_nxt;
  logic [7:0]  res_opc_r, res_opc_nxt;
  logic [4:0]  res_form_r, res_form_nxt;
  logic [2:0]  res_len_r, res_len_nxt;
  logic [7:0]  res_a_r, res_a_nxt;
  logic [7:0]  res_b_r, res_b_nxt;
  logic [7:0]  res_c_r, res_c_nxt;
  logic [15:0] res_tgt_r, res_tgt_nxt;
  logic        emit;

  // lookup page is the held prefix only right after a prefix byte
  logic [1:0]      lk_page;
  hc11p_pkg::dec_t dec;

  // final-byte view of the instruction being completed
  logic [1:0] fin_nops;
  logic [7:0] fin_last;
  logic [2:0] fin_len;
  logic [15:0] next_addr;

  assign lk_page = (phase_r == PH_PFX) ? page_r : hc11p_pkg::PAGE_NONE;

  hc11p_decode u_decode (
    .page      (lk_page),
    .code_byte (s1_byte_r),
    .dec       (dec)
  );

  // handshake: input register drains whenever the result register can take a value
  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !s1_go);

  always_comb begin
    addr_nxt  = addr_r;
    page_nxt  = page_r;
    opc_nxt   = opc_r;
    pend_nxt  = pend_r;
    phase_nxt = phase_r;
    op1_nxt   = op1_r;
    op2_nxt   = op2_r;
    form_nxt  = form_r;

    emit           = 1'b0;
    res_status_nxt = hc11p_pkg::ST_OK;
    res_page_nxt   = page_r;
    res_opc_nxt    = s1_byte_r;
    res_form_nxt   = 5'd0;
    res_len_nxt    = 3'd1;
    res_a_nxt      = 8'd0;
    res_b_nxt      = 8'd0;
    res_c_nxt      = 8'd0;
    res_tgt_nxt    = 16'd0;

    // instruction finished by this byte: opcode-only or last operand
    fin_nops = pend_r;
    fin_last = s1_byte_r;
    if (phase_r != PH_OPND) begin
      fin_nops = dec.nops;
      fin_last = 8'd0;
    end
    if (phase_r == PH_OPND) fin_nops = hc11p_pkg::form_nops(form_r);
    fin_len = 3'({1'b0, fin_nops}) + 3'd1
            + ((phase_r == PH_FIRST) ? 3'd0 : {2'b0, (page_r != hc11p_pkg::PAGE_NONE)});

    if (phase_r == PH_FIRST || phase_r == PH_PFX) begin
      if (phase_r == PH_FIRST) page_nxt = hc11p_pkg::PAGE_NONE;
      if (dec.kind == hc11p_pkg::KIND_BAD) begin
        emit         = 1'b1;
        res_page_nxt = (phase_r == PH_FIRST) ? hc11p_pkg::PAGE_NONE : page_r;
        res_status_nxt = (phase_r == PH_FIRST) ? hc11p_pkg::ST_BAD_BASE
                                                : hc11p_pkg::ST_BAD_PFX;
        res_len_nxt  = (phase_r == PH_FIRST) ? 3'd1 : 3'd2;
        page_nxt     = hc11p_pkg::PAGE_NONE;
        phase_nxt    = PH_FIRST;
      end else if (dec.kind == hc11p_pkg::KIND_PREFIX) begin
        // only reachable from PH_FIRST: page lookups never return the prefix class
        page_nxt  = dec.pfx_page;
        phase_nxt = PH_PFX;
      end else begin
        opc_nxt  = s1_byte_r;
        form_nxt = dec.form;
        pend_nxt = dec.nops;
        if (dec.nops == 2'd0) begin
          emit         = 1'b1;
          res_page_nxt = (phase_r == PH_FIRST) ? hc11p_pkg::PAGE_NONE : page_r;
          res_form_nxt = dec.form;
          res_len_nxt  = fin_len;
          phase_nxt    = PH_FIRST;
        end else begin
          phase_nxt = PH_OPND;
        end
      end
    end else begin
      if (pend_r <= 2'd1) begin
        // last operand byte
        emit         = 1'b1;
        res_opc_nxt  = opc_r;
        res_form_nxt = form_r;
        res_len_nxt  = fin_len;
        case (fin_nops)
          2'd1: res_a_nxt = fin_last;
          2'd2: begin
            res_a_nxt = op1_r;
            res_b_nxt = fin_last;
          end
          2'd3: begin
            res_a_nxt = op1_r;
            res_b_nxt = op2_r;
            res_c_nxt = fin_last;
          end
          default: res_a_nxt = 8'd0;
        endcase
        // target: next instruction's address plus the signed offset byte
        if (form_r == hc11p_pkg::FORM_REL || form_r >= hc11p_pkg::FORM_BRSET_LO) begin
          res_tgt_nxt = addr_r + {13'd0, fin_len} + {{8{fin_last[7]}}, fin_last};
        end
        pend_nxt  = 2'd0;
        phase_nxt = PH_FIRST;
      end else begin
        if (pend_r == fin_nops) op1_nxt = s1_byte_r;
        else                    op2_nxt = s1_byte_r;
        pend_nxt = pend_r - 2'd1;
      end
    end

    next_addr = addr_r + {13'd0, res_len_nxt};
    if (emit) addr_nxt = next_addr;
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || (s1_go && emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      addr_r      <= 16'd0;
      page_r      <= hc11p_pkg::PAGE_NONE;
      opc_r       <= 8'd0;
      pend_r      <= 2'd0;
      phase_r     <= PH_FIRST;
      op1_r       <= 8'd0;
      op2_r       <= 8'd0;
      form_r      <= 5'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        addr_r  <= cfg_start_address;
        page_r  <= hc11p_pkg::PAGE_NONE;
        pend_r  <= 2'd0;
        phase_r <= PH_FIRST;
      end else if (s1_go) begin
        addr_r  <= addr_nxt;
        page_r  <= page_nxt;
        opc_r   <= opc_nxt;
        pend_r  <= pend_nxt;
        phase_r <= phase_nxt;
        op1_r   <= op1_nxt;
        op2_r   <= op2_nxt;
        form_r  <= form_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte_r <= in_code_byte;
    if (s1_go && emit) begin
      res_addr_r   <= addr_r;
      res_status_r <= res_status_nxt;
      res_page_r   <= res_page_nxt;
      res_opc_r    <= res_opc_nxt;
      res_form_r   <= res_form_nxt;
      res_len_r    <= res_len_nxt;
      res_a_r      <= res_a_nxt;
      res_b_r      <= res_b_nxt;
      res_c_r      <= res_c_nxt;
      res_tgt_r    <= res_tgt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_inst_address  = res_addr_r;
  assign out_status        = res_status_r;
  assign out_page          = res_page_r;
  assign out_opcode        = res_opc_r;
  assign out_form          = res_form_r;
  assign out_length        = res_len_r;
  assign out_operand_a     = res_a_r;
  assign out_operand_b     = res_b_r;
  assign out_operand_c     = res_c_r;
  assign out_branch_target = res_tgt_r;

endmodule

`default_nettype wire
